@@ design/sorted_deadline_timer_queue_macros.svh @@
// Assertion macros for the timer queue.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define SDTQ_ASSERT_COMB(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
// antecedent at one edge implies consequent at the next
`define SDTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDTQ_ASSERT_COMB(lbl, cond, msg)
`define SDTQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/sdtq_pkg.sv @@
package sdtq_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_FIRE      = 16;
    localparam int DL_W          = 64;
    localparam int LIM_W         = 8;
    localparam int ID_W          = 4;
    localparam int KIND_W        = 3;
    localparam int REQ_W         = 2;

    localparam logic [LIM_W-1:0] DEF_LIMIT_RST = 8'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_OK  = 3'd0,
        KIND_ADD_REJ = 3'd1,
        KIND_REMOVED = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_NO_FIRE = 3'd4
    } kind_t;

    typedef struct packed {
        logic capture;   // latch the input transaction
        logic exec;      // apply the request, clear scan state
        logic scan_rd;   // read one slot of the table
        logic load_out;  // move one result into the output register
    } cmd_t;

    typedef struct packed {
        logic req_none;  // request type gives no result
        logic scan_end;  // last slot address issued this cycle
        logic out_free;  // output register can take a result
        logic res_last;  // pending result is the final one of the request
    } sts_t;

endpackage

@@ design/sdtq_ctrl.sv @@
module sdtq_ctrl import sdtq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.req_none ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last slot read is processed here
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    if (sts.res_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/sdtq_dpath.sv @@
module sdtq_dpath import sdtq_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [REQ_W-1:0]  s_req_type,
    input  logic [ID_W-1:0]   s_timer_id,
    input  logic [DL_W-1:0]   s_deadline,
    input  logic [LIM_W-1:0]  s_retry_limit,
    input  logic [DL_W-1:0]   s_tick_value,
    input  logic              cfg_wr_en,
    input  logic [LIM_W-1:0]  cfg_wr_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_resp_kind,
    output logic [ID_W-1:0]   m_fired_id,
    output logic              m_auto_removed,
    output logic [DL_W-1:0]   m_next_deadline,
    output logic              m_last
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // captured request
    req_t             req_reg;
    logic [ID_W-1:0]  id_reg;
    logic [DL_W-1:0]  dl_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [DL_W-1:0]  tick_reg;

    logic [DL_W-1:0]      cur_time_reg;
    logic [LIM_W-1:0]     def_lim_reg;
    logic [NUM_SLOTS-1:0] armed_reg;
    logic                 add_ok_reg;
    logic                 fire_en_reg;

    // slot table
    logic [DL_W-1:0]  dl_mem  [NUM_SLOTS];
    logic [LIM_W-1:0] cnt_mem [NUM_SLOTS];
    logic [LIM_W-1:0] lim_mem [NUM_SLOTS];

    // scan read stage
    logic [SLOT_W-1:0] scan_idx_reg;
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [DL_W-1:0]   rd_dl_reg;
    logic [LIM_W-1:0]  rd_cnt_reg;
    logic [LIM_W-1:0]  rd_lim_reg;

    logic [DL_W-1:0] best_reg;
    logic            found_reg;

    // fired list, kept sorted by (deadline, slot)
    logic [DL_W-1:0]     list_dl_reg  [MAX_FIRE];
    logic [DL_W-1:0]     list_dl_next [MAX_FIRE];
    logic [ID_W-1:0]     list_id_reg  [MAX_FIRE];
    logic [ID_W-1:0]     list_id_next [MAX_FIRE];
    logic [MAX_FIRE-1:0] list_rm_reg, list_rm_next;
    logic [MAX_FIRE-1:0] list_vld_reg, list_vld_next;
    logic [MAX_FIRE-1:0] gt;

    // output register
    logic             out_vld_reg;
    kind_t            out_kind_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic             out_rm_reg;
    logic [DL_W-1:0]  out_nd_reg;
    logic             out_last_reg;

    logic [SLOT_W-1:0] slot_idx;
    logic              id_ok;
    logic              add_ok;
    logic              tick_ok;
    logic [LIM_W-1:0]  eff_lim;
    logic              p_armed;
    logic              p_fire;
    logic [LIM_W-1:0]  p_cnt;
    logic              p_rm;
    logic              p_keep;
    logic              emit_fired;

    kind_t            res_kind;
    logic [ID_W-1:0]  res_id;
    logic             res_rm;
    logic             res_last;

    assign slot_idx = SLOT_W'(id_reg);
    assign id_ok    = (32'(id_reg) < NUM_SLOTS);
    assign add_ok   = id_ok && !armed_reg[slot_idx] && (dl_reg > cur_time_reg);
    assign tick_ok  = (|armed_reg) && (tick_reg != '0) && (cur_time_reg < tick_reg);
    assign eff_lim  = (lim_reg != '0) ? lim_reg : def_lim_reg;

    assign p_armed = rd_vld_reg && armed_reg[rd_idx_reg];
    assign p_fire  = p_armed && fire_en_reg && (rd_dl_reg <= tick_reg);
    assign p_cnt   = rd_cnt_reg + LIM_W'(1);
    assign p_rm    = (p_cnt >= rd_lim_reg);
    // slot still armed once this tick is done
    assign p_keep  = p_armed && !(p_fire && p_rm);

    assign emit_fired = (req_reg == REQ_TICK) && list_vld_reg[0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= req_t'(s_req_type);
            id_reg   <= s_timer_id;
            dl_reg   <= s_deadline;
            lim_reg  <= s_retry_limit;
            tick_reg <= s_tick_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_lim_reg <= DEF_LIMIT_RST;
        end else if (cfg_wr_en) begin
            def_lim_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_time_reg <= '0;
            armed_reg    <= '0;
            add_ok_reg   <= 1'b0;
            fire_en_reg  <= 1'b0;
        end else if (cmd.exec) begin
            add_ok_reg  <= add_ok;
            fire_en_reg <= (req_reg == REQ_TICK) && tick_ok;
            if (req_reg == REQ_TICK && tick_ok) begin
                cur_time_reg <= tick_reg;
            end
            if (req_reg == REQ_ADD && add_ok) begin
                armed_reg[slot_idx] <= 1'b1;
            end
            if (req_reg == REQ_REMOVE && id_ok) begin
                armed_reg[slot_idx] <= 1'b0;
            end
        end else if (p_fire && p_rm) begin
            armed_reg[rd_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && req_reg == REQ_ADD && add_ok) begin
            dl_mem[slot_idx]  <= dl_reg;
            lim_mem[slot_idx] <= eff_lim;
            cnt_mem[slot_idx] <= '0;
        end else if (p_fire) begin
            cnt_mem[rd_idx_reg] <= p_cnt;
        end
        if (cmd.scan_rd) begin
            rd_idx_reg <= scan_idx_reg;
            rd_dl_reg  <= dl_mem[scan_idx_reg];
            rd_cnt_reg <= cnt_mem[scan_idx_reg];
            rd_lim_reg <= lim_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.exec) begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end else begin
                if (cmd.scan_rd) begin
                    scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                end
                if (p_keep && (!found_reg || rd_dl_reg < best_reg)) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!cmd.exec && p_keep && (!found_reg || rd_dl_reg < best_reg)) begin
            best_reg <= rd_dl_reg;
        end
    end

    // invalid entries count as later than anything
    always_comb begin
        for (int k = 0; k < MAX_FIRE; k++) begin
            gt[k] = !list_vld_reg[k] || (list_dl_reg[k] > rd_dl_reg);
        end
    end

    always_comb begin
        list_dl_next  = list_dl_reg;
        list_id_next  = list_id_reg;
        list_rm_next  = list_rm_reg;
        list_vld_next = list_vld_reg;
        if (cmd.exec) begin
            list_vld_next = '0;
        end else if (p_fire) begin
            // insert after all entries with deadline not later; ties keep slot order
            for (int k = MAX_FIRE - 1; k > 0; k--) begin
                if (gt[k]) begin
                    if (gt[k-1]) begin
                        list_dl_next[k]  = list_dl_reg[k-1];
                        list_id_next[k]  = list_id_reg[k-1];
                        list_rm_next[k]  = list_rm_reg[k-1];
                        list_vld_next[k] = list_vld_reg[k-1];
                    end else begin
                        list_dl_next[k]  = rd_dl_reg;
                        list_id_next[k]  = ID_W'(rd_idx_reg);
                        list_rm_next[k]  = p_rm;
                        list_vld_next[k] = 1'b1;
                    end
                end
            end
            if (gt[0]) begin
                list_dl_next[0]  = rd_dl_reg;
                list_id_next[0]  = ID_W'(rd_idx_reg);
                list_rm_next[0]  = p_rm;
                list_vld_next[0] = 1'b1;
            end
        end else if (cmd.load_out && emit_fired) begin
            for (int k = 0; k < MAX_FIRE - 1; k++) begin
                list_dl_next[k]  = list_dl_reg[k+1];
                list_id_next[k]  = list_id_reg[k+1];
                list_rm_next[k]  = list_rm_reg[k+1];
                list_vld_next[k] = list_vld_reg[k+1];
            end
            list_vld_next[MAX_FIRE-1] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_vld_reg <= '0;
        end else begin
            list_vld_reg <= list_vld_next;
        end
        list_dl_reg <= list_dl_next;
        list_id_reg <= list_id_next;
        list_rm_reg <= list_rm_next;
    end

    always_comb begin
        res_kind = KIND_NO_FIRE;
        res_id   = '0;
        res_rm   = 1'b0;
        res_last = 1'b1;
        if (emit_fired) begin
            res_kind = KIND_FIRED;
            res_id   = list_id_reg[0];
            res_rm   = list_rm_reg[0];
            res_last = !list_vld_reg[1];
        end else begin
            case (req_reg)
                REQ_ADD: begin
                    res_kind = add_ok_reg ? KIND_ADD_OK : KIND_ADD_REJ;
                    res_id   = id_reg;
                end
                REQ_REMOVE: begin
                    res_kind = KIND_REMOVED;
                    res_id   = id_reg;
                end
                default: begin
                    res_kind = KIND_NO_FIRE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_kind_reg <= res_kind;
            out_id_reg   <= res_id;
            out_rm_reg   <= res_rm;
            out_nd_reg   <= found_reg ? best_reg : '0;
            out_last_reg <= res_last;
        end
    end

    assign sts.req_none = (req_reg == REQ_NONE);
    assign sts.scan_end = (scan_idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign sts.out_free = !out_vld_reg || m_ready;
    assign sts.res_last = res_last;

    assign m_valid         = out_vld_reg;
    assign m_resp_kind     = out_kind_reg;
    assign m_fired_id      = out_id_reg;
    assign m_auto_removed  = out_rm_reg;
    assign m_next_deadline = out_nd_reg;
    assign m_last          = out_last_reg;

endmodule

@@ design/sorted_deadline_timer_queue.sv @@
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    req_type, timer_id, deadline, retry_limit, tick_value
// m_        out  m_valid/m_ready    resp_kind, fired_id, auto_removed, next_deadline, last
// cfg_      in   cfg_wr_en          cfg_wr_data (default retry limit)
//
// After a request is accepted, the slot table is scanned sequentially, one slot per
// cycle, before its first result; each further result (one per fired timer) goes
// into the output register as soon as that register is free.
// Reset (aresetn low, synchronous) disarms all slots, zeroes the current tick and
// sets the default retry limit to 10. No clearing pass.
// m_ready low holds the result in the output register; the next request is taken
// once the final result of the current one is in that register.
`include "sorted_deadline_timer_queue_macros.svh"

module sorted_deadline_timer_queue import sdtq_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [REQ_W-1:0]  s_req_type,
    input  logic [ID_W-1:0]   s_timer_id,
    input  logic [DL_W-1:0]   s_deadline,
    input  logic [LIM_W-1:0]  s_retry_limit,
    input  logic [DL_W-1:0]   s_tick_value,
    input  logic              cfg_wr_en,
    input  logic [LIM_W-1:0]  cfg_wr_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_resp_kind,
    output logic [ID_W-1:0]   m_fired_id,
    output logic              m_auto_removed,
    output logic [DL_W-1:0]   m_next_deadline,
    output logic              m_last
);

    cmd_t ctrl_cmd;
    sts_t dp_sts;

    sdtq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (ctrl_cmd)
    );

    sdtq_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (ctrl_cmd),
        .sts             (dp_sts),
        .s_req_type      (s_req_type),
        .s_timer_id      (s_timer_id),
        .s_deadline      (s_deadline),
        .s_retry_limit   (s_retry_limit),
        .s_tick_value    (s_tick_value),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_resp_kind     (m_resp_kind),
        .m_fired_id      (m_fired_id),
        .m_auto_removed  (m_auto_removed),
        .m_next_deadline (m_next_deadline),
        .m_last          (m_last)
    );

    `SDTQ_ASSERT_NEXT(a_accept_blocks, s_valid && s_ready, !s_ready, "input taken twice")
    `SDTQ_ASSERT_COMB(a_no_overwrite, !ctrl_cmd.load_out || !m_valid || m_ready, "result overwritten")
    `SDTQ_ASSERT_COMB(a_rm_only_fired, !m_valid || m_resp_kind == KIND_FIRED || !m_auto_removed, "auto_removed on non-fire result")
    `SDTQ_ASSERT_NEXT(a_ready_after_last, ctrl_cmd.load_out && dp_sts.res_last, s_ready, "not ready after final result")

endmodule

@@ tb/sv/tb_sorted_deadline_timer_queue.sv @@
module tb_sorted_deadline_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import sdtq_pkg::*;

    localparam int NSLOT     = NUM_SLOTS_DEF;
    localparam int DRAIN_CYC = NSLOT + 4 + 16;
    localparam int DIR_N     = 19;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    localparam logic [DL_W-1:0] MAX64 = {DL_W{1'b1}};

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  id;
        logic [DL_W-1:0]  dl;
        logic [LIM_W-1:0] lim;
        logic [DL_W-1:0]  tick;
    } timer_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              rm;
        logic [DL_W-1:0]   nd;
        logic              last;
    } timer_resp_t;

    // typed rows are single-result requests: auto_removed 0, last 1
    typedef struct packed {
        timer_req_t        rq;
        logic              typed;
        logic [KIND_W-1:0] w_kind;
        logic [ID_W-1:0]   w_id;
        logic [DL_W-1:0]   w_nd;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [0:DIR_N-1] = '{
        // empty table: tick ignored, time stays at zero
        '{'{REQ_TICK,   4'd0,  64'd0,  8'd0,   64'd100}, 1'b1, KIND_NO_FIRE, 4'd0,  64'd0},
        '{'{REQ_REMOVE, 4'd5,  64'd0,  8'd0,   64'd0},   1'b1, KIND_REMOVED, 4'd5,  64'd0},
        '{'{REQ_ADD,    4'd0,  64'd0,  8'd3,   64'd0},   1'b1, KIND_ADD_REJ, 4'd0,  64'd0},
        '{'{REQ_ADD,    4'd15, MAX64,  8'd255, 64'd0},   1'b1, KIND_ADD_OK,  4'd15, MAX64},
        '{'{REQ_ADD,    4'd15, 64'd50, 8'd1,   64'd0},   1'b1, KIND_ADD_REJ, 4'd15, MAX64},
        '{'{REQ_ADD,    4'd0,  64'd10, 8'd0,   64'd0},   1'b1, KIND_ADD_OK,  4'd0,  64'd10},
        '{'{REQ_ADD,    4'd1,  64'd10, 8'd1,   64'd0},   1'b1, KIND_ADD_OK,  4'd1,  64'd10},
        '{'{REQ_ADD,    4'd2,  64'd5,  8'd2,   64'd0},   1'b1, KIND_ADD_OK,  4'd2,  64'd5},
        '{'{REQ_ADD,    4'd7,  64'd30, 8'd3,   64'd0},   1'b1, KIND_ADD_OK,  4'd7,  64'd5},
        '{'{REQ_TICK,   4'd0,  64'd0,  8'd0,   64'd0},   1'b1, KIND_NO_FIRE, 4'd0,  64'd5},
        '{'{REQ_TICK,   4'd0,  64'd0,  8'd0,   64'd4},   1'b0, KIND_ADD_OK,  4'd0,  64'd0},
        '{'{REQ_TICK,   4'd0,  64'd0,  8'd0,   64'd4},   1'b0, KIND_ADD_OK,  4'd0,  64'd0},
        '{'{REQ_ADD,    4'd3,  64'd4,  8'd1,   64'd0},   1'b0, KIND_ADD_OK,  4'd0,  64'd0},
        '{'{REQ_NONE,   4'd9,  MAX64,  8'd255, MAX64},   1'b0, KIND_ADD_OK,  4'd0,  64'd0},
        '{'{REQ_TICK,   4'd0,  64'd0,  8'd0,   64'd10},  1'b0, KIND_ADD_OK,  4'd0,  64'd0},
        '{'{REQ_TICK,   4'd0,  64'd0,  8'd0,   64'd30},  1'b0, KIND_ADD_OK,  4'd0,  64'd0},
        '{'{REQ_REMOVE, 4'd7,  64'd0,  8'd0,   64'd0},   1'b0, KIND_ADD_OK,  4'd0,  64'd0},
        '{'{REQ_REMOVE, 4'd15, 64'd0,  8'd0,   64'd0},   1'b0, KIND_ADD_OK,  4'd0,  64'd0},
        '{'{REQ_TICK,   4'd0,  64'd0,  8'd0,   MAX64},   1'b0, KIND_ADD_OK,  4'd0,  64'd0}
    };

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type    = '0;
    logic [ID_W-1:0]   s_timer_id    = '0;
    logic [DL_W-1:0]   s_deadline    = '0;
    logic [LIM_W-1:0]  s_retry_limit = '0;
    logic [DL_W-1:0]   s_tick_value  = '0;
    logic              cfg_wr_en     = 1'b0;
    logic [LIM_W-1:0]  cfg_wr_data   = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [KIND_W-1:0] m_resp_kind;
    logic [ID_W-1:0]   m_fired_id;
    logic              m_auto_removed;
    logic [DL_W-1:0]   m_next_deadline;
    logic              m_last;

    // timer table mirror
    logic [DL_W-1:0]  slot_due  [NSLOT];
    bit               slot_on   [NSLOT];
    logic [LIM_W-1:0] slot_hits [NSLOT];
    logic [LIM_W-1:0] slot_cap  [NSLOT];
    logic [DL_W-1:0]  table_now = '0;
    logic [LIM_W-1:0] dflt_cap  = DEF_LIMIT_RST;

    timer_resp_t step_results    [$];
    timer_resp_t pending_results [$];
    timer_resp_t head;

    bit idle_on   = 1'b1;
    int rdy_left  = 0;
    int err_cnt   = 0;
    int n_req     = 0;
    int n_res     = 0;
    int n_fired   = 0;
    int n_autorm  = 0;

    sorted_deadline_timer_queue u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_timer_id      (s_timer_id),
        .s_deadline      (s_deadline),
        .s_retry_limit   (s_retry_limit),
        .s_tick_value    (s_tick_value),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_resp_kind     (m_resp_kind),
        .m_fired_id      (m_fired_id),
        .m_auto_removed  (m_auto_removed),
        .m_next_deadline (m_next_deadline),
        .m_last          (m_last)
    );

    always #10 aclk = ~aclk;

    initial begin
        foreach (slot_on[i]) begin
            slot_on[i]   = 1'b0;
            slot_due[i]  = '0;
            slot_hits[i] = '0;
            slot_cap[i]  = '0;
        end
    end

    function automatic logic [DL_W-1:0] earliest_due();
        logic [DL_W-1:0] best;
        bit              found;
        best  = '0;
        found = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            if (slot_on[i] && (!found || slot_due[i] < best)) begin
                best  = slot_due[i];
                found = 1'b1;
            end
        end
        return best;
    endfunction

    // applies one request to the table mirror, leaves its results in step_results
    task automatic advance_timer_table(input timer_req_t r);
        bit              seen [NSLOT];
        int              pick;
        bit              hunting;
        bit              any_on;
        logic [DL_W-1:0] nd;
        timer_resp_t     res;
        step_results.delete();
        res = '0;
        case (r.req)
            REQ_ADD: begin
                res.id = r.id;
                if (slot_on[r.id] || r.dl <= table_now) begin
                    res.kind = KIND_ADD_REJ;
                end else begin
                    slot_on[r.id]   = 1'b1;
                    slot_due[r.id]  = r.dl;
                    slot_hits[r.id] = '0;
                    slot_cap[r.id]  = (r.lim != '0) ? r.lim : dflt_cap;
                    res.kind        = KIND_ADD_OK;
                end
                step_results.push_back(res);
            end
            REQ_REMOVE: begin
                slot_on[r.id] = 1'b0;
                res.kind      = KIND_REMOVED;
                res.id        = r.id;
                step_results.push_back(res);
            end
            REQ_TICK: begin
                any_on = 1'b0;
                foreach (slot_on[i]) any_on |= slot_on[i];
                if (any_on && r.tick != '0 && r.tick > table_now) begin
                    table_now = r.tick;
                    foreach (seen[i]) seen[i] = 1'b0;
                    hunting = 1'b1;
                    // earliest due first, lower slot wins a tie
                    while (hunting && step_results.size() < MAX_FIRE) begin
                        pick = -1;
                        for (int i = 0; i < NSLOT; i++) begin
                            if (slot_on[i] && !seen[i] && slot_due[i] <= r.tick)
                                if (pick < 0 || slot_due[i] < slot_due[pick])
                                    pick = i;
                        end
                        if (pick < 0) begin
                            hunting = 1'b0;
                        end else begin
                            seen[pick]      = 1'b1;
                            slot_hits[pick] = slot_hits[pick] + 8'd1;
                            res.kind        = KIND_FIRED;
                            res.id          = pick[ID_W-1:0];
                            res.rm          = (slot_hits[pick] >= slot_cap[pick]);
                            if (res.rm)
                                slot_on[pick] = 1'b0;
                            step_results.push_back(res);
                        end
                    end
                end
                if (step_results.size() == 0) begin
                    res      = '0;
                    res.kind = KIND_NO_FIRE;
                    step_results.push_back(res);
                end
            end
            default: ;
        endcase
        nd = earliest_due();
        foreach (step_results[k]) begin
            res      = step_results[k];
            res.nd   = nd;
            res.last = (k == step_results.size() - 1);
            step_results[k] = res;
        end
    endtask

    task automatic issue(input timer_req_t r, input bit typed, input timer_resp_t want);
        s_valid       <= 1'b1;
        s_req_type    <= r.req;
        s_timer_id    <= r.id;
        s_deadline    <= r.dl;
        s_retry_limit <= r.lim;
        s_tick_value  <= r.tick;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        n_req++;
        advance_timer_table(r);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
    endtask

    task automatic sender_pause();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // waits out every expected result plus the scan time of a silent request
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic set_default_limit(input logic [LIM_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        dflt_cap     = v;
    endtask

    function automatic timer_req_t rand_req();
        timer_req_t r;
        int         sel;
        int         pick;
        r.req  = REQ_NONE;
        r.id   = $urandom_range(0, NSLOT - 1);
        r.dl   = {$urandom, $urandom};
        r.lim  = $urandom_range(0, 255);
        r.tick = {$urandom, $urandom};
        sel    = $urandom_range(0, 99);
        pick   = $urandom_range(0, 9);
        if (sel < 45) begin
            r.req = REQ_ADD;
            if (pick < 7)
                r.dl = table_now + $urandom_range(1, 40);
            else if (pick == 7)
                r.dl = table_now;
            pick = $urandom_range(0, 9);
            if (pick < 3)
                r.lim = '0;
            else if (pick < 8)
                r.lim = $urandom_range(1, 3);
        end else if (sel < 60) begin
            r.req = REQ_REMOVE;
        end else if (sel < 96) begin
            r.req = REQ_TICK;
            if (pick < 7)
                r.tick = table_now + $urandom_range(1, 25);
            else if (pick == 7)
                r.tick = '0;
            else if (pick == 8)
                r.tick = (table_now > 64'd3) ? table_now - $urandom_range(0, 3) : table_now;
            else
                r.tick[DL_W-1] = 1'b0;  // big jump, kept clear of the top so adds still land
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        timer_req_t r;
        int         done;
        done = 0;
        while (done < count) begin
            r = rand_req();
            sender_pause();
            issue(r, 1'b0, '0);
            if (r.req != REQ_NONE)
                done++;
        end
    endtask

    // clear the table, arm every slot near the same deadline, then fire them all
    task automatic run_burst();
        timer_req_t      r;
        logic [DL_W-1:0] due;
        due = table_now + 64'd5;
        for (int i = 0; i < NSLOT; i++) begin
            r     = '0;
            r.req = REQ_REMOVE;
            r.id  = i;
            sender_pause();
            issue(r, 1'b0, '0);
        end
        for (int i = 0; i < NSLOT; i++) begin
            r     = '0;
            r.req = REQ_ADD;
            r.id  = i;
            r.dl  = due - $urandom_range(0, 3);
            r.lim = $urandom_range(0, 2);
            sender_pause();
            issue(r, 1'b0, '0);
        end
        r      = '0;
        r.req  = REQ_TICK;
        r.tick = due;
        sender_pause();
        issue(r, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rdy_left <= 0;
        end else if (rdy_left == 0) begin
            m_ready  <= !(idle_on && $urandom_range(0, 2) == 0);
            rdy_left <= $urandom_range(1, 13);
        end else begin
            rdy_left <= rdy_left - 1;
        end
    end

    task automatic check_field(input string name, input logic [DL_W-1:0] want,
                               input logic [DL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction, kind %0h id %0h", $time,
                         m_resp_kind, m_fired_id);
                err_cnt++;
            end else begin
                head = pending_results.pop_front();
                check_field("resp_kind", head.kind, m_resp_kind);
                check_field("fired_id", head.id, m_fired_id);
                check_field("auto_removed", head.rm, m_auto_removed);
                check_field("next_deadline", head.nd, m_next_deadline);
                check_field("last", head.last, m_last);
                n_res++;
                if (head.kind == KIND_FIRED)
                    n_fired++;
                if (head.rm)
                    n_autorm++;
            end
        end
    end

    initial begin
        timer_resp_t      want;
        logic [LIM_W-1:0] lim_plan [4];
        lim_plan[0] = 8'd255;
        lim_plan[1] = 8'd1;
        lim_plan[2] = $urandom_range(2, 254);
        lim_plan[3] = 8'd10;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // zero default: first firing removes the slot
        set_default_limit(8'd0);
        for (int i = 0; i < DIR_N; i++) begin
            want      = '0;
            want.kind = DIR_TAB[i].w_kind;
            want.id   = DIR_TAB[i].w_id;
            want.nd   = DIR_TAB[i].w_nd;
            want.last = 1'b1;
            sender_pause();
            issue(DIR_TAB[i].rq, DIR_TAB[i].typed, want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            set_default_limit(lim_plan[ph]);
            if (ph == 3)
                idle_on = 1'b0;
            run_random(40);
            if (ph % 2 == 1)
                run_burst();
        end
        drain();

        $display("Checked %0d results from %0d requests: %0d timer firings, %0d auto removals.",
                 n_res, n_req, n_fired, n_autorm);
        $display("Default retry limit swept over 0, 1, 255, 10 and %0d.", lim_plan[2]);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
